>>> hdl/ocw_pkg.sv
// Shared constants, result codes and elaboration-time helpers for the
// Otto cycle work estimator. No dependencies.
`default_nettype none

package ocw_pkg;

  localparam int PRES_W  = 24;
  localparam int VOL_W   = 24;
  localparam int TEMP_W  = 20;
  localparam int WORK_W  = 48;
  localparam int STAT_W  = 2;
  localparam int MANT_F  = 30;
  localparam int MANT_W  = 31;

  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_ZERO = 2'd1;
  localparam logic [STAT_W-1:0] STAT_SAT  = 2'd2;

  localparam logic [WORK_W-1:0] LIM_POS = {1'b0, {(WORK_W-1){1'b1}}};
  localparam logic [WORK_W-1:0] LIM_NEG = {1'b1, {(WORK_W-1){1'b0}}};

  // Position of the highest set bit; zero for a zero input.
  function automatic logic [4:0] msb_index(input logic [VOL_W-1:0] v);
    logic [4:0] n;
    n = '0;
    for (int i = 1; i < VOL_W; i++) begin
      if (v[i]) n = 5'(i);
    end
    return n;
  endfunction

  // Q30 value of 2^(2^-idx): repeated integer square roots starting from 2.0.
  function automatic logic [MANT_W-1:0] exp_coef(input int idx);
    logic [63:0] c;
    logic [63:0] v;
    logic [63:0] res;
    logic [63:0] bit_w;
    c = 64'd1 << 31;
    for (int i = 1; i <= idx; i++) begin
      v   = c << 30;
      res = '0;
      for (int k = 31; k >= 0; k--) begin
        bit_w = 64'd1 << (2 * k);
        if (v >= res + bit_w) begin
          v   = v - (res + bit_w);
          res = (res >> 1) + bit_w;
        end else begin
          res = res >> 1;
        end
      end
      c = res;
    end
    return c[MANT_W-1:0];
  endfunction

endpackage

`default_nettype wire

>>> hdl/otto_cycle_work_estimate_top.sv
// Top level of the Otto cycle work estimator: the whole pipelined datapath.
// Depends on ocw_pkg for constants, result codes and coefficient helpers.
`default_nettype none

// The block accepts one request per clock unless every stage is full and the
// output is held, and returns one result per request, in order. The pipeline
// has one stage per log2 fraction bit for the two volumes, one stage per exp2
// fraction bit, one stage per 16-bit digit of the wide product and a 48-stage
// radix-2 divider. Every stage has its own valid bit and moves whenever the
// stage after it is free, so empty slots are filled while a finished result
// waits at the output.
module otto_cycle_work_estimate_top #(
  parameter int FRAC_BITS = 16
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       in_valid,
  output logic                      in_ready,
  input  wire  [23:0]               in_start_pressure,
  input  wire  [23:0]               in_start_volume,
  input  wire  [19:0]               in_start_temperature,
  input  wire  [23:0]               in_compressed_volume,
  input  wire  [19:0]               in_heat_rise,
  output logic                      out_valid,
  input  wire                       out_ready,
  output logic signed [47:0]        out_work_microjoules,
  output logic [1:0]                out_status
);

  localparam int F    = FRAC_BITS;
  localparam int LGW  = F + 5;
  localparam int XW   = F + 6;
  localparam int K    = F + 9;
  localparam int MW   = F + 8;
  localparam int EW   = F + 5;
  localparam int SW   = F + 10;
  localparam int SHR  = 43 - F;
  localparam int WY   = F + 35;
  localparam int ND   = (WY + 15) / 16;
  localparam int YPW  = ND * 16;
  localparam int NW   = F + 103;
  localparam int NPW  = 103;
  localparam int DDW  = 55;
  localparam int QW   = ocw_pkg::WORK_W;
  localparam int MTW  = ocw_pkg::MANT_W;

  localparam logic [MW-1:0] DIV5_M = MW'(((64'd1 << K) + 64'd4) / 64'd5);

  localparam int ST_T    = F + 1;
  localparam int ST_Q    = F + 2;
  localparam int ST_EXP0 = F + 3;
  localparam int ST_SH   = 2 * F + 3;
  localparam int ST_Y1   = 2 * F + 4;
  localparam int ST_Y2   = 2 * F + 5;
  localparam int ST_MUL0 = 2 * F + 6;
  localparam int ST_PRE  = ST_MUL0 + ND;
  localparam int ST_DIV0 = ST_PRE + 1;
  localparam int ST_OUT  = ST_DIV0 + QW;
  localparam int NS      = ST_OUT + 1;

  typedef struct packed {
    logic        z;
    logic [23:0] p1;
    logic [23:0] v1;
    logic [23:0] v2;
    logic [19:0] t1;
    logic [19:0] dt;
  } base_t;

  typedef struct packed {
    base_t          b;
    logic [4:0]     n1;
    logic [4:0]     n2;
    logic [MTW-1:0] m1;
    logic [MTW-1:0] m2;
    logic [F-1:0]   f1;
    logic [F-1:0]   f2;
  } log_t;

  typedef struct packed {
    base_t         b;
    logic          tneg;
    logic [XW-1:0] x;
  } tq_t;

  typedef struct packed {
    base_t          b;
    logic [EW-1:0]  e;
    logic [MTW-1:0] me;
  } ex_t;

  typedef struct packed {
    base_t         b;
    logic [SW-1:0] s;
  } sh_t;

  typedef struct packed {
    logic           z;
    logic           neg;
    logic [23:0]    v1;
    logic [23:0]    dv;
    logic [SW+23:0] sv2;
    logic [43:0]    x1;
    logic [43:0]    d1;
  } y1_t;

  typedef struct packed {
    logic           z;
    logic           neg;
    logic [67:0]    x2;
    logic [YPW-1:0] y;
    logic [DDW-1:0] dd;
    logic [NW-1:0]  acc;
  } ml_t;

  typedef struct packed {
    logic           z;
    logic           neg;
    logic           ovf;
    logic [DDW-1:0] dd;
    logic [DDW-1:0] rem;
    logic [QW-1:0]  lo;
  } dv_t;

  // Per-stage valid bits and move enables.
  logic [NS-1:0] vld_r;
  logic [NS-1:0] vld_nxt;
  logic [NS-1:0] en;

  assign en[NS-1] = !vld_r[NS-1] || out_ready;
  genvar k;
  generate
    for (k = 0; k < NS - 1; k++) begin : g_en
      assign en[k] = !vld_r[k] || en[k+1];
    end
  endgenerate

  assign vld_nxt = {vld_r[NS-2:0], in_valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= (vld_nxt & en) | (vld_r & ~en);
    end
  end

  assign in_ready  = en[0];
  assign out_valid = vld_r[NS-1];

  // Log2 of both volumes: normalize, then one squaring per fraction bit.
  log_t lg_r   [0:F];
  log_t lg_nxt [0:F];

  always_comb begin
    lg_nxt[0].b.z  = (in_start_volume == '0) || (in_compressed_volume == '0) ||
                     (in_start_temperature == '0);
    lg_nxt[0].b.p1 = in_start_pressure;
    lg_nxt[0].b.v1 = in_start_volume;
    lg_nxt[0].b.v2 = in_compressed_volume;
    lg_nxt[0].b.t1 = in_start_temperature;
    lg_nxt[0].b.dt = in_heat_rise;
    lg_nxt[0].n1   = ocw_pkg::msb_index(in_start_volume);
    lg_nxt[0].n2   = ocw_pkg::msb_index(in_compressed_volume);
    lg_nxt[0].m1   = MTW'(in_start_volume) << (5'd30 - lg_nxt[0].n1);
    lg_nxt[0].m2   = MTW'(in_compressed_volume) << (5'd30 - lg_nxt[0].n2);
    lg_nxt[0].f1   = '0;
    lg_nxt[0].f2   = '0;
  end

  always_ff @(posedge clk) begin
    if (en[0]) lg_r[0] <= lg_nxt[0];
  end

  generate
    for (k = 0; k < F; k++) begin : g_log
      logic [2*MTW-1:0] sq1;
      logic [2*MTW-1:0] sq2;
      always_comb begin
        sq1 = lg_r[k].m1 * lg_r[k].m1;
        sq2 = lg_r[k].m2 * lg_r[k].m2;
        lg_nxt[k+1]    = lg_r[k];
        // A square of 2.0 or more yields a one bit and is halved.
        lg_nxt[k+1].m1 = sq1[61] ? sq1[61:31] : sq1[60:30];
        lg_nxt[k+1].m2 = sq2[61] ? sq2[61:31] : sq2[60:30];
        lg_nxt[k+1].f1 = {lg_r[k].f1[F-2:0], sq1[61]};
        lg_nxt[k+1].f2 = {lg_r[k].f2[F-2:0], sq2[61]};
      end
      always_ff @(posedge clk) begin
        if (en[k+1]) lg_r[k+1] <= lg_nxt[k+1];
      end
    end
  endgenerate

  // Twice the log difference, prepared for a floor division by five.
  tq_t          tq_r;
  tq_t          tq_nxt;
  logic [LGW-1:0] l1;
  logic [LGW-1:0] l2;
  logic [F+6:0]   tv;

  always_comb begin
    l1          = {lg_r[F].n1, lg_r[F].f1};
    l2          = {lg_r[F].n2, lg_r[F].f2};
    tv          = ({2'b00, l2} - {2'b00, l1}) << 1;
    tq_nxt.b    = lg_r[F].b;
    tq_nxt.tneg = tv[F+6];
    // A negative value takes the ceiling of its magnitude, which gives floor.
    tq_nxt.x    = tv[F+6] ? XW'(-tv + (F+7)'(4)) : XW'(tv);
  end

  always_ff @(posedge clk) begin
    if (en[ST_T]) tq_r <= tq_nxt;
  end

  // Exponent, then exp2 with one coefficient multiply per fraction bit.
  ex_t ex_r   [0:F];
  ex_t ex_nxt [0:F];
  logic [XW+MW-1:0] qp;
  logic [EW-1:0]    qv;

  always_comb begin
    qp          = tq_r.x * DIV5_M;
    qv          = qp[XW+MW-1:K];
    ex_nxt[0].b  = tq_r.b;
    ex_nxt[0].e  = tq_r.tneg ? -qv : qv;
    ex_nxt[0].me = {1'b1, {ocw_pkg::MANT_F{1'b0}}};
  end

  always_ff @(posedge clk) begin
    if (en[ST_Q]) ex_r[0] <= ex_nxt[0];
  end

  generate
    for (k = 0; k < F; k++) begin : g_exp
      localparam logic [MTW-1:0] COEF = ocw_pkg::exp_coef(k + 1);
      logic [2*MTW-1:0] prod;
      always_comb begin
        prod        = ex_r[k].me * COEF;
        ex_nxt[k+1] = ex_r[k];
        if (ex_r[k].e[F-1-k]) ex_nxt[k+1].me = prod[60:30];
      end
      always_ff @(posedge clk) begin
        if (en[ST_EXP0+k]) ex_r[k+1] <= ex_nxt[k+1];
      end
    end
  endgenerate

  // Scale the mantissa by the integer part of the exponent.
  sh_t        sh_r;
  sh_t        sh_nxt;
  logic [4:0] ip;
  logic [4:0] sh_u;
  logic [52:0] sh_wide;

  always_comb begin
    ip       = ex_r[F].e[EW-1:F];
    sh_u     = ip + 5'd13;
    sh_wide  = 53'(ex_r[F].me) << sh_u;
    sh_nxt.b = ex_r[F].b;
    sh_nxt.s = SW'(sh_wide >> SHR);
  end

  always_ff @(posedge clk) begin
    if (en[ST_SH]) sh_r <= sh_nxt;
  end

  y1_t y1_r;
  y1_t y1_nxt;

  always_comb begin
    y1_nxt.z   = sh_r.b.z;
    y1_nxt.neg = sh_r.b.v2 > sh_r.b.v1;
    y1_nxt.v1  = sh_r.b.v1;
    y1_nxt.dv  = y1_nxt.neg ? (sh_r.b.v2 - sh_r.b.v1) : (sh_r.b.v1 - sh_r.b.v2);
    y1_nxt.sv2 = sh_r.s * sh_r.b.v2;
    y1_nxt.x1  = sh_r.b.p1 * sh_r.b.dt;
    y1_nxt.d1  = sh_r.b.v2 * sh_r.b.t1;
  end

  always_ff @(posedge clk) begin
    if (en[ST_Y1]) y1_r <= y1_nxt;
  end

  // Wide product P1*dT*|V1-V2|*y, one 16-bit digit of y per stage.
  ml_t ml_r   [0:ND];
  ml_t ml_nxt [0:ND];

  always_comb begin
    ml_nxt[0].z   = y1_r.z;
    ml_nxt[0].neg = y1_r.neg;
    ml_nxt[0].x2  = y1_r.x1 * y1_r.dv;
    ml_nxt[0].y   = (YPW'(y1_r.v1) << F) + YPW'(y1_r.sv2);
    ml_nxt[0].dd  = y1_r.d1 * 11'd2000;
    ml_nxt[0].acc = '0;
  end

  always_ff @(posedge clk) begin
    if (en[ST_Y2]) ml_r[0] <= ml_nxt[0];
  end

  generate
    for (k = 0; k < ND; k++) begin : g_mul
      logic [NW-1:0] pp;
      always_comb begin
        pp             = NW'(ml_r[k].x2 * ml_r[k].y[16*k +: 16]);
        ml_nxt[k+1]     = ml_r[k];
        ml_nxt[k+1].acc = ml_r[k].acc + (pp << (16 * k));
      end
      always_ff @(posedge clk) begin
        if (en[ST_MUL0+k]) ml_r[k+1] <= ml_nxt[k+1];
      end
    end
  endgenerate

  // Divider: quotient of the product by 2000*V2*T1*2^F, 48 bits plus overflow.
  dv_t dv_r   [0:QW];
  dv_t dv_nxt [0:QW];
  logic [NPW-1:0] np;

  always_comb begin
    np            = ml_r[ND].acc[NW-1:F];
    dv_nxt[0].z   = ml_r[ND].z;
    dv_nxt[0].neg = ml_r[ND].neg;
    dv_nxt[0].dd  = ml_r[ND].dd;
    dv_nxt[0].rem = np[NPW-1:QW];
    dv_nxt[0].ovf = np[NPW-1:QW] >= ml_r[ND].dd;
    dv_nxt[0].lo  = np[QW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en[ST_PRE]) dv_r[0] <= dv_nxt[0];
  end

  generate
    for (k = 0; k < QW; k++) begin : g_div
      logic [DDW:0] r2;
      logic         ge;
      always_comb begin
        r2              = {dv_r[k].rem, dv_r[k].lo[QW-1]};
        ge              = r2 >= {1'b0, dv_r[k].dd};
        dv_nxt[k+1]     = dv_r[k];
        dv_nxt[k+1].rem = ge ? DDW'(r2 - {1'b0, dv_r[k].dd}) : r2[DDW-1:0];
        dv_nxt[k+1].lo  = {dv_r[k].lo[QW-2:0], ge};
      end
      always_ff @(posedge clk) begin
        if (en[ST_DIV0+k]) dv_r[k+1] <= dv_nxt[k+1];
      end
    end
  endgenerate

  // Saturation, sign and special cases into the output register.
  logic [QW-1:0] work_r;
  logic [QW-1:0] work_nxt;
  logic [1:0]    status_r;
  logic [1:0]    status_nxt;
  logic          sat;
  logic [QW-1:0] mag;

  always_comb begin
    sat = dv_r[QW].ovf ||
          (dv_r[QW].neg ? (dv_r[QW].lo > ocw_pkg::LIM_NEG) : dv_r[QW].lo[QW-1]);
    mag = sat ? (dv_r[QW].neg ? ocw_pkg::LIM_NEG : ocw_pkg::LIM_POS) : dv_r[QW].lo;
    if (dv_r[QW].z) begin
      work_nxt   = '0;
      status_nxt = ocw_pkg::STAT_ZERO;
    end else begin
      work_nxt   = dv_r[QW].neg ? -mag : mag;
      status_nxt = sat ? ocw_pkg::STAT_SAT : ocw_pkg::STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en[ST_OUT]) begin
      work_r   <= work_nxt;
      status_r <= status_nxt;
    end
  end

  assign out_work_microjoules = $signed(work_r);
  assign out_status           = status_r;

  // The input only stalls when every stage is full and the output is held.
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (&vld_r) && !out_ready)
    else $error("input stalled with a free pipeline slot");

  a_zero_work: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ocw_pkg::STAT_ZERO |-> out_work_microjoules == '0)
    else $error("zero-input result carries nonzero work");

  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == ocw_pkg::STAT_SAT |->
      work_r == ocw_pkg::LIM_POS || work_r == ocw_pkg::LIM_NEG)
    else $error("saturated result is not at a limit");

  a_hold_moves: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(work_r) && $stable(status_r))
    else $error("stalled result changed");

endmodule

`default_nettype wire
